// ===== hdl/text_console_character_engine_core_defines.svh =====
// ----------------------------------------------------------------------------
// Text console character engine assertion macros
// Simulation-only assertion wrappers; they expand to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_CHARACTER_ENGINE_CORE_DEFINES_SVH
`define TEXT_CONSOLE_CHARACTER_ENGINE_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define TCCE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("text console engine assertion failed");
`define TCCE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("text console engine assertion failed");
`else
`define TCCE_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define TCCE_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== hdl/tcce_pkg.sv =====
// ----------------------------------------------------------------------------
// Text console character engine package
// Screen geometry, operation and register codes, and controller interface types.
// ----------------------------------------------------------------------------
package tcce_pkg;

    localparam int COLUMNS = 80;
    localparam int ROWS    = 25;
    localparam int CELLS   = COLUMNS * ROWS;

    localparam int ADDR_W  = 11;
    localparam int COL_W   = 7;
    localparam int ROW_W   = 5;
    localparam int CELL_W  = 16;
    localparam int COLOR_W = 4;
    localparam int CFG_IDX_W = 2;

    localparam logic [1:0] FUNC_PUT   = 2'd0;
    localparam logic [1:0] FUNC_CLEAR = 2'd1;
    localparam logic [1:0] FUNC_READ  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_FOREGROUND = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BACKGROUND = 2'd1;

    localparam logic [7:0] CH_LF        = 8'h0A;
    localparam logic [7:0] CH_CR        = 8'h0D;
    localparam logic [7:0] CH_BS        = 8'h08;
    localparam logic [7:0] CH_SPACE     = 8'h20;

    localparam logic [CELL_W-1:0] RESET_CELL = 16'h0720;
    localparam logic [COLOR_W-1:0] RESET_FOREGROUND = 4'h7;
    localparam logic [COLOR_W-1:0] RESET_BACKGROUND = 4'h0;

    typedef struct packed {
        logic accept;
        logic copy_step;
        logic fill_step;
        logic fill_init;
        logic cnt_inc;
        logic cnt_zero;
        logic load_out;
    } ctrl_cmd_t;

    typedef struct packed {
        logic acc_clear;
        logic acc_scroll;
        logic cnt_copy_end;
        logic cnt_last;
    } dp_status_t;

endpackage

// ===== hdl/tcce_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with a registered read data output.
// ----------------------------------------------------------------------------
module tcce_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/tcce_datapath.sv =====
// ----------------------------------------------------------------------------
// Text console character engine datapath
// Cursor and color registers, cell store, scan counter and result registers.
// ----------------------------------------------------------------------------
module tcce_datapath
    import tcce_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  ctrl_cmd_t            cmd,
    output dp_status_t           status,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [COLOR_W-1:0]   cfg_wdata,
    input  logic [1:0]           func,
    input  logic [7:0]           char_code,
    input  logic [ADDR_W-1:0]    cell_index,
    output logic [COL_W-1:0]     cursor_col,
    output logic [ROW_W-1:0]     cursor_row,
    output logic [ADDR_W-1:0]    cursor_position,
    output logic [CELL_W-1:0]    cell_value,
    output logic                 scrolled
);

    logic [COLOR_W-1:0] fg_reg, fg_next;
    logic [COLOR_W-1:0] bg_reg, bg_next;
    logic [COL_W-1:0]   col_reg, col_next;
    logic [ROW_W-1:0]   row_reg, row_next;
    logic [ADDR_W-1:0]  cnt_reg, cnt_next;
    logic               rd_hit_reg, rd_hit_next;
    logic               scroll_reg, scroll_next;

    logic [COL_W-1:0]   out_col_reg;
    logic [ROW_W-1:0]   out_row_reg;
    logic [ADDR_W-1:0]  out_pos_reg;
    logic [CELL_W-1:0]  out_cell_reg;
    logic               out_scroll_reg;

    logic [7:0]         attr;
    logic [CELL_W-1:0]  blank;
    logic [ADDR_W-1:0]  cur_addr;
    logic [COL_W:0]     put_col;
    logic [ROW_W:0]     put_row;
    logic               put_we;
    logic [ADDR_W-1:0]  put_waddr;
    logic [CELL_W-1:0]  put_wdata;
    logic               put_scroll;
    logic               is_put;
    logic               is_clear;
    logic               is_read;
    logic               read_hit;

    logic               ram_we;
    logic [ADDR_W-1:0]  ram_waddr;
    logic [CELL_W-1:0]  ram_wdata;
    logic               ram_re;
    logic [ADDR_W-1:0]  ram_raddr;
    logic [CELL_W-1:0]  ram_rdata;

    assign attr     = {bg_reg, fg_reg};
    assign blank    = {attr, CH_SPACE};
    assign cur_addr = ADDR_W'(row_reg) * ADDR_W'(COLUMNS) + ADDR_W'(col_reg);
    assign is_put   = (func == FUNC_PUT);
    assign is_clear = (func == FUNC_CLEAR);
    assign is_read  = (func == FUNC_READ);
    assign read_hit = is_read && (cell_index < ADDR_W'(CELLS));

    always_comb
    begin
        put_col    = {1'b0, col_reg};
        put_row    = {1'b0, row_reg};
        put_we     = 1'b0;
        put_waddr  = cur_addr;
        put_wdata  = {attr, char_code};
        put_scroll = 1'b0;
        case (char_code)
            CH_LF:
            begin
                put_col = '0;
                put_row = put_row + 1'b1;
            end
            CH_CR:
            begin
                put_col = '0;
            end
            CH_BS:
            begin
                if (col_reg != '0)
                begin
                    put_col   = put_col - 1'b1;
                    put_we    = 1'b1;
                    put_waddr = cur_addr - 1'b1;
                    put_wdata = blank;
                end
            end
            default:
            begin
                put_we  = 1'b1;
                put_col = put_col + 1'b1;
            end
        endcase
        if (put_col >= (COL_W + 1)'(COLUMNS))
        begin
            put_col = '0;
            put_row = put_row + 1'b1;
        end
        if (put_row >= (ROW_W + 1)'(ROWS))
        begin
            put_row    = (ROW_W + 1)'(ROWS - 1);
            put_scroll = 1'b1;
        end
    end

    assign status.acc_clear    = is_clear;
    assign status.acc_scroll   = is_put && put_scroll;
    assign status.cnt_copy_end = (cnt_reg == ADDR_W'(CELLS - COLUMNS));
    assign status.cnt_last     = (cnt_reg == ADDR_W'(CELLS - 1));

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = cnt_reg;
        ram_wdata = blank;
        ram_re    = 1'b0;
        ram_raddr = cnt_reg + ADDR_W'(COLUMNS);
        if (cmd.accept)
        begin
            ram_we    = is_put && put_we;
            ram_waddr = put_waddr;
            ram_wdata = put_wdata;
            ram_re    = read_hit;
            ram_raddr = cell_index;
        end
        else if (cmd.copy_step)
        begin
            ram_we    = (cnt_reg != '0);
            ram_waddr = cnt_reg - 1'b1;
            ram_wdata = ram_rdata;
            ram_re    = !status.cnt_copy_end;
        end
        else if (cmd.fill_step)
        begin
            ram_we = 1'b1;
        end
        else if (cmd.fill_init)
        begin
            ram_we    = 1'b1;
            ram_wdata = RESET_CELL;
        end
    end

    tcce_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELLS)
    ) u_cells (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        fg_next     = fg_reg;
        bg_next     = bg_reg;
        col_next    = col_reg;
        row_next    = row_reg;
        cnt_next    = cnt_reg;
        rd_hit_next = rd_hit_reg;
        scroll_next = scroll_reg;
        if (cfg_wr_en && (cfg_index == REG_FOREGROUND))
        begin
            fg_next = cfg_wdata;
        end
        if (cfg_wr_en && (cfg_index == REG_BACKGROUND))
        begin
            bg_next = cfg_wdata;
        end
        if (cmd.accept)
        begin
            rd_hit_next = read_hit;
            scroll_next = status.acc_scroll;
            if (is_put)
            begin
                col_next = put_col[COL_W-1:0];
                row_next = put_row[ROW_W-1:0];
            end
            else if (is_clear)
            begin
                col_next = '0;
                row_next = '0;
            end
        end
        if (cmd.cnt_zero)
        begin
            cnt_next = '0;
        end
        else if (cmd.cnt_inc)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fg_reg     <= RESET_FOREGROUND;
            bg_reg     <= RESET_BACKGROUND;
            col_reg    <= '0;
            row_reg    <= '0;
            cnt_reg    <= '0;
            rd_hit_reg <= 1'b0;
            scroll_reg <= 1'b0;
        end
        else
        begin
            fg_reg     <= fg_next;
            bg_reg     <= bg_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
            cnt_reg    <= cnt_next;
            rd_hit_reg <= rd_hit_next;
            scroll_reg <= scroll_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_col_reg    <= col_reg;
            out_row_reg    <= row_reg;
            out_pos_reg    <= cur_addr;
            out_cell_reg   <= rd_hit_reg ? ram_rdata : '0;
            out_scroll_reg <= scroll_reg;
        end
    end

    assign cursor_col      = out_col_reg;
    assign cursor_row      = out_row_reg;
    assign cursor_position = out_pos_reg;
    assign cell_value      = out_cell_reg;
    assign scrolled        = out_scroll_reg;

endmodule

// ===== hdl/tcce_ctrl.sv =====
// ----------------------------------------------------------------------------
// Text console character engine controller
// Sequences the clearing pass, item execution, scroll copy, fills and result hand-off.
// ----------------------------------------------------------------------------
module tcce_ctrl
    import tcce_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    output logic       out_valid,
    input  logic       out_ready,
    input  dp_status_t status,
    output ctrl_cmd_t  cmd
);

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_COPY,
        ST_FILL,
        ST_EMIT
    } state_t;

    state_t state_reg, state_next;
    logic   in_ready_reg, in_ready_next;
    logic   out_valid_reg, out_valid_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_INIT:
            begin
                cmd.fill_init = 1'b1;
                cmd.cnt_inc   = 1'b1;
                if (status.cnt_last)
                begin
                    cmd.cnt_zero = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid && in_ready_reg)
                begin
                    cmd.accept = 1'b1;
                    if (status.acc_clear)
                    begin
                        state_next = ST_FILL;
                    end
                    else if (status.acc_scroll)
                    begin
                        state_next = ST_COPY;
                    end
                    else
                    begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_COPY:
            begin
                cmd.copy_step = 1'b1;
                if (status.cnt_copy_end)
                begin
                    state_next = ST_FILL;
                end
                else
                begin
                    cmd.cnt_inc = 1'b1;
                end
            end
            ST_FILL:
            begin
                cmd.fill_step = 1'b1;
                cmd.cnt_inc   = 1'b1;
                if (status.cnt_last)
                begin
                    cmd.cnt_zero = 1'b1;
                    state_next   = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_INIT;
            end
        endcase
        in_ready_next = (state_next == ST_IDLE);
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            in_ready_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            in_ready_reg  <= in_ready_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = in_ready_reg;
    assign out_valid = out_valid_reg;

endmodule

// ===== hdl/text_console_character_engine_core.sv =====
// ----------------------------------------------------------------------------
// Text console character engine
// Puts that do not scroll, reads and unknown operations go from ST_IDLE through ST_EMIT to the result.
// A put that scrolls runs a row copy through the cell RAM read port, then a blank
// fill of the bottom row. A clear runs a blank fill of every cell.
// One transaction is in work at a time. After reset a clearing pass
// writes every cell to 0x0720 while in_ready stays low.
// ----------------------------------------------------------------------------
`include "text_console_character_engine_core_defines.svh"

module text_console_character_engine_core
    import tcce_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [COLOR_W-1:0]   cfg_wdata,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [1:0]           func,
    input  logic [7:0]           char_code,
    input  logic [ADDR_W-1:0]    cell_index,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [COL_W-1:0]     cursor_col,
    output logic [ROW_W-1:0]     cursor_row,
    output logic [ADDR_W-1:0]    cursor_position,
    output logic [CELL_W-1:0]    cell_value,
    output logic                 scrolled
);

    ctrl_cmd_t  cmd;
    dp_status_t status;

    tcce_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    tcce_datapath u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .func            (func),
        .char_code       (char_code),
        .cell_index      (cell_index),
        .cursor_col      (cursor_col),
        .cursor_row      (cursor_row),
        .cursor_position (cursor_position),
        .cell_value      (cell_value),
        .scrolled        (scrolled)
    );

    `TCCE_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready)
    `TCCE_ASSERT_IMP(a_scroll_on_last_row, clk, rst_n, out_valid && scrolled, cursor_row == ROW_W'(ROWS - 1))
    `TCCE_ASSERT_IMP(a_position_matches, clk, rst_n, out_valid, (cursor_col < COL_W'(COLUMNS)) && (cursor_position == ADDR_W'(cursor_row) * ADDR_W'(COLUMNS) + ADDR_W'(cursor_col)))

endmodule

// ===== bench/text_console_character_engine_core_checker.sv =====
// ----------------------------------------------------------------------------
// Text console character engine checker
// Watches the register port and both channels. It keeps a shadow screen, cursor
// and color pair, predicts the report for every accepted input transaction,
// and compares each accepted output transaction with the oldest prediction.
// ----------------------------------------------------------------------------
module text_console_character_engine_core_checker
    import tcce_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [COLOR_W-1:0]   cfg_wdata,
    input  logic                 in_valid,
    input  logic                 in_ready,
    input  logic [1:0]           func,
    input  logic [7:0]           char_code,
    input  logic [ADDR_W-1:0]    cell_index,
    input  logic                 out_valid,
    input  logic                 out_ready,
    input  logic [COL_W-1:0]     cursor_col,
    input  logic [ROW_W-1:0]     cursor_row,
    input  logic [ADDR_W-1:0]    cursor_position,
    input  logic [CELL_W-1:0]    cell_value,
    input  logic                 scrolled,
    output int                   outstanding,
    output int                   mismatch_count
);

    typedef struct packed {
        logic [COL_W-1:0]  col;
        logic [ROW_W-1:0]  row;
        logic [ADDR_W-1:0] position;
        logic [CELL_W-1:0] cell_word;
        logic              scrolled;
    } console_report_t;

    logic [CELL_W-1:0]  shadow_screen [CELLS];
    int                 shadow_col;
    int                 shadow_row;
    logic [COLOR_W-1:0] shadow_fg;
    logic [COLOR_W-1:0] shadow_bg;
    console_report_t    console_reports [$];

    function automatic logic [CELL_W-1:0] blank_glyph();
        return {shadow_bg, shadow_fg, CH_SPACE};
    endfunction

    task automatic report_mismatch(input string what);
        $display("%0t: %s", $time, what);
        mismatch_count++;
    endtask

    task automatic advance_console(input logic [1:0] op, input logic [7:0] ch,
                                   input logic [ADDR_W-1:0] idx);
        console_report_t rep;
        int addr;
        rep = '0;
        case (op)
            FUNC_PUT:
            begin
                if (ch == CH_LF)
                begin
                    shadow_col = 0;
                    shadow_row++;
                end
                else if (ch == CH_CR)
                begin
                    shadow_col = 0;
                end
                else if (ch == CH_BS)
                begin
                    if (shadow_col > 0)
                    begin
                        shadow_col--;
                        shadow_screen[shadow_row * COLUMNS + shadow_col] = blank_glyph();
                    end
                end
                else
                begin
                    shadow_screen[shadow_row * COLUMNS + shadow_col] = {shadow_bg, shadow_fg, ch};
                    shadow_col++;
                end
                if (shadow_col >= COLUMNS)
                begin
                    shadow_col = 0;
                    shadow_row++;
                end
                if (shadow_row >= ROWS)
                begin
                    for (addr = 0; addr < CELLS - COLUMNS; addr++)
                        shadow_screen[addr] = shadow_screen[addr + COLUMNS];
                    for (addr = CELLS - COLUMNS; addr < CELLS; addr++)
                        shadow_screen[addr] = blank_glyph();
                    shadow_row = ROWS - 1;
                    rep.scrolled = 1'b1;
                end
            end
            FUNC_CLEAR:
            begin
                for (addr = 0; addr < CELLS; addr++)
                    shadow_screen[addr] = blank_glyph();
                shadow_col = 0;
                shadow_row = 0;
            end
            FUNC_READ:
            begin
                if (int'(idx) < CELLS)
                    rep.cell_word = shadow_screen[idx];
            end
            default:
            begin
            end
        endcase
        rep.col      = COL_W'(shadow_col);
        rep.row      = ROW_W'(shadow_row);
        rep.position = ADDR_W'(shadow_row * COLUMNS + shadow_col);
        console_reports.push_back(rep);
    endtask

    task automatic check_report();
        console_report_t want;
        if (console_reports.size() == 0)
        begin
            report_mismatch("result transaction with no request outstanding");
        end
        else
        begin
            want = console_reports.pop_front();
            if (cursor_col !== want.col)
                report_mismatch($sformatf("cursor_col got %0d expected %0d",
                                          cursor_col, want.col));
            if (cursor_row !== want.row)
                report_mismatch($sformatf("cursor_row got %0d expected %0d",
                                          cursor_row, want.row));
            if (cursor_position !== want.position)
                report_mismatch($sformatf("cursor_position got %0d expected %0d",
                                          cursor_position, want.position));
            if (cell_value !== want.cell_word)
                report_mismatch($sformatf("cell_value got 0x%04h expected 0x%04h",
                                          cell_value, want.cell_word));
            if (scrolled !== want.scrolled)
                report_mismatch($sformatf("scrolled got %0b expected %0b",
                                          scrolled, want.scrolled));
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CELLS; i++)
                shadow_screen[i] = RESET_CELL;
            shadow_col     = 0;
            shadow_row     = 0;
            shadow_fg      = RESET_FOREGROUND;
            shadow_bg      = RESET_BACKGROUND;
            mismatch_count = 0;
            console_reports.delete();
            outstanding <= 0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    REG_FOREGROUND: shadow_fg = cfg_wdata;
                    REG_BACKGROUND: shadow_bg = cfg_wdata;
                    default:
                    begin
                    end
                endcase
            end
            if (out_valid && out_ready)
                check_report();
            if (in_valid && in_ready)
                advance_console(func, char_code, cell_index);
            outstanding <= console_reports.size();
        end
    end

endmodule

// ===== bench/text_console_character_engine_core_tb.sv =====
// ----------------------------------------------------------------------------
// Text console character engine testbench
// Drives directed and random put, clear and read transactions under several
// color settings, with random idling on both channels, a long output stall
// and pauses that drain the block. The checker predicts and compares.
// ----------------------------------------------------------------------------
module text_console_character_engine_core_tb;
    import tcce_pkg::*;

    localparam logic [1:0]           FUNC_UNDEFINED = 2'd3;
    localparam logic [CFG_IDX_W-1:0] UNUSED_REG_LO  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] UNUSED_REG_HI  = 2'd3;
    localparam int WATCHDOG_LIMIT   = 25000;
    localparam int DRAIN_CYCLES     = 2100;
    localparam int HOLD_CYCLES      = 400;
    localparam int PHASES           = 8;
    localparam int ITEMS_PER_PHASE  = 250;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [COLOR_W-1:0]   cfg_wdata;
    logic                 in_valid;
    logic                 in_ready;
    logic [1:0]           func;
    logic [7:0]           char_code;
    logic [ADDR_W-1:0]    cell_index;
    logic                 out_valid;
    logic                 out_ready;
    logic [COL_W-1:0]     cursor_col;
    logic [ROW_W-1:0]     cursor_row;
    logic [ADDR_W-1:0]    cursor_position;
    logic [CELL_W-1:0]    cell_value;
    logic                 scrolled;
    int                   outstanding;
    int                   mismatch_count;

    bit hold_asked   = 1'b0;
    bit hold_done    = 1'b0;
    bit steady_phase = 1'b0;
    int idle_cycles  = 0;

    text_console_character_engine_core dut (.*);

    text_console_character_engine_core_checker checker_inst (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady_phase || r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 15);
        return $urandom_range(30, 80);
    endfunction

    task automatic offer(input logic [1:0] op, input logic [7:0] ch,
                         input logic [ADDR_W-1:0] idx);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        func       <= op;
        char_code  <= ch;
        cell_index <= idx;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic offer_random(input int lf_pct, input int clear_permille);
        int r;
        int sub;
        logic [ADDR_W-1:0] idx;
        r = $urandom_range(0, 999);
        if (r < clear_permille)
        begin
            offer(FUNC_CLEAR, 8'($urandom), 11'($urandom));
        end
        else if (r < clear_permille + 5)
        begin
            offer(FUNC_UNDEFINED, 8'($urandom), 11'($urandom));
        end
        else if (r < clear_permille + 250)
        begin
            if ($urandom_range(0, 99) < 3)
                idx = 11'($urandom_range(CELLS, 2047));
            else
                idx = 11'($urandom_range(0, CELLS - 1));
            offer(FUNC_READ, 8'($urandom), idx);
        end
        else
        begin
            sub = $urandom_range(0, 99);
            if (sub < lf_pct)
                offer(FUNC_PUT, CH_LF, 11'($urandom));
            else if (sub < lf_pct + 3)
                offer(FUNC_PUT, CH_CR, 11'($urandom));
            else if (sub < lf_pct + 11)
                offer(FUNC_PUT, CH_BS, 11'($urandom));
            else
                offer(FUNC_PUT, 8'($urandom_range(0, 255)), 11'($urandom));
        end
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic program_colors(input logic [COLOR_W-1:0] fg, input logic [COLOR_W-1:0] bg,
                                  input bit stray);
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_FOREGROUND;
        cfg_wdata <= fg;
        @(posedge clk);
        cfg_index <= REG_BACKGROUND;
        cfg_wdata <= bg;
        @(posedge clk);
        if (stray)
        begin
            cfg_index <= UNUSED_REG_LO;
            cfg_wdata <= ~fg;
            @(posedge clk);
            cfg_index <= UNUSED_REG_HI;
            cfg_wdata <= ~bg;
            @(posedge clk);
        end
        cfg_wr_en <= 1'b0;
    endtask

    initial
    begin
        int r;
        int n;
        out_ready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (hold_asked && !hold_done)
            begin
                hold_done = 1'b1;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if (steady_phase)
            begin
                out_ready <= 1'b1;
                @(posedge clk);
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 60)
                begin
                    out_ready <= 1'b1;
                    n = $urandom_range(1, 16);
                end
                else
                begin
                    out_ready <= 1'b0;
                    if (r < 90)
                        n = $urandom_range(1, 3);
                    else if (r < 98)
                        n = $urandom_range(4, 12);
                    else
                        n = $urandom_range(20, 60);
                end
                repeat (n) @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("text_console_character_engine_core_tb: done, errors");
            $finish;
        end
    end

    initial
    begin
        int lf_pct;
        int clear_permille;
        logic [COLOR_W-1:0] fg_pick;
        logic [COLOR_W-1:0] bg_pick;
        rst_n      <= 1'b0;
        cfg_wr_en  <= 1'b0;
        cfg_index  <= REG_FOREGROUND;
        cfg_wdata  <= '0;
        in_valid   <= 1'b0;
        func       <= FUNC_PUT;
        char_code  <= '0;
        cell_index <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        program_colors(RESET_FOREGROUND, RESET_BACKGROUND, 1'b1);

        offer(FUNC_READ, 8'h00, ADDR_W'(0));
        offer(FUNC_READ, 8'hFF, ADDR_W'(CELLS - 1));
        offer(FUNC_READ, 8'h00, ADDR_W'(CELLS));
        offer(FUNC_READ, 8'h00, 11'h7FF);
        offer(FUNC_UNDEFINED, 8'hFF, 11'h7FF);
        offer(FUNC_PUT, CH_BS, ADDR_W'(0));
        offer(FUNC_PUT, 8'h00, ADDR_W'(0));
        offer(FUNC_PUT, 8'hFF, ADDR_W'(0));
        offer(FUNC_PUT, 8'h80, ADDR_W'(0));
        offer(FUNC_PUT, 8'h7F, ADDR_W'(0));
        for (int i = 0; i < 4; i++)
            offer(FUNC_READ, 8'h00, 11'(i));
        settle();

        program_colors(4'hF, 4'hF, 1'b0);
        offer(FUNC_PUT, 8'h41, ADDR_W'(0));
        offer(FUNC_PUT, CH_BS, ADDR_W'(0));
        offer(FUNC_READ, 8'h00, ADDR_W'(4));
        offer(FUNC_READ, 8'h00, ADDR_W'(3));
        offer(FUNC_PUT, CH_CR, ADDR_W'(0));
        offer(FUNC_PUT, CH_LF, ADDR_W'(0));
        offer(FUNC_PUT, 8'h55, ADDR_W'(0));
        offer(FUNC_READ, 8'h00, ADDR_W'(COLUMNS));
        offer(FUNC_CLEAR, 8'h00, ADDR_W'(0));
        offer(FUNC_READ, 8'h00, ADDR_W'(0));
        offer(FUNC_READ, 8'h00, ADDR_W'(CELLS - 1));
        settle();

        for (int phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0:
                begin
                    fg_pick = 4'h0;
                    bg_pick = 4'h0;
                end
                1:
                begin
                    fg_pick = 4'hF;
                    bg_pick = 4'hF;
                end
                2:
                begin
                    fg_pick = 4'hF;
                    bg_pick = 4'h0;
                end
                3:
                begin
                    fg_pick = 4'h0;
                    bg_pick = 4'hF;
                end
                default:
                begin
                    fg_pick = 4'($urandom_range(0, 15));
                    bg_pick = 4'($urandom_range(0, 15));
                end
            endcase
            lf_pct         = (phase % 3 == 0) ? 12 : ((phase % 3 == 1) ? 4 : 8);
            clear_permille = (phase % 2 == 1) ? 6 : 0;
            steady_phase   = (phase == 3);
            program_colors(fg_pick, bg_pick, 1'b0);
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                if (phase == 2 && n == 40)
                    hold_asked = 1'b1;
                offer_random(lf_pct, clear_permille);
            end
            settle();
        end
        steady_phase = 1'b0;

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("text_console_character_engine_core_tb: done, clean");
        else
            $display("text_console_character_engine_core_tb: done, errors");
        $finish;
    end

endmodule
